// ===== hdl/chained_hash_key_value_table_defines.svh =====
// ----------------------------------------------------------------------------
// Chained hash key-value table assertion macros
// Assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_KEY_VALUE_TABLE_DEFINES_SVH
`define CHAINED_HASH_KEY_VALUE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define CHKV_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("assertion failed");
`define CHKV_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CHKV_ASSERT_IMP(lbl, clk, rstn, a, c)
`define CHKV_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ===== hdl/chkv_pkg.sv =====
// ----------------------------------------------------------------------------
// Chained hash key-value table package
// Operation and status codes, item classes and the queued item type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package chkv_pkg;
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_FIND = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_NULLKEY = 2'd3;

    typedef enum logic [1:0] {
        K_ADD  = 2'd0,
        K_LOOK = 2'd1,
        K_NULL = 2'd2,
        K_NOP  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  op;
        kind_t       kind;
        logic [63:0] key;
        logic [63:0] value;
    } item_t;
endpackage

// ===== hdl/chained_hash_key_value_table.sv =====
// ----------------------------------------------------------------------------
// Chained hash key-value table
// Key-value store with separate chaining over a fixed node pool.
// The front end reduces the key to its bucket. The back end answers nop, null
// key and full from idle, adds in S_ADD1 to S_ADD3, walks the chain for a find,
// and for a delete walks it, then relinks in S_REL1 to S_REL3. The front end
// takes a new item once the last is queued, the back end only when idle and
// no output is pending. Reset clears all links first; no item is taken then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chained_hash_key_value_table_defines.svh"
module chained_hash_key_value_table #(
    parameter int NODES   = 1024,
    parameter int BUCKETS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], key[65:2], value[129:66]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], found_value[65:2], entry_count[76:66]
    output logic [79:0]  m_tdata
);
    import chkv_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int QW = $bits(item_t) + BW;

    logic          enable, push, pop, q_full, q_empty;
    item_t         push_item, q_item;
    logic [BW-1:0] push_bucket, q_bucket;
    logic [QW-1:0] q_rdata;

    chkv_front #(.BUCKETS(BUCKETS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .enable(enable),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .push(push), .push_item(push_item), .push_bucket(push_bucket),
        .q_full(q_full));

    chkv_fifo #(.WIDTH(QW)) u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push),
        .wdata({push_item, push_bucket}), .pop(pop), .rdata(q_rdata),
        .full(q_full), .empty(q_empty));

    assign q_item   = q_rdata[QW-1:BW];
    assign q_bucket = q_rdata[BW-1:0];

    chkv_back #(.NODES(NODES), .BUCKETS(BUCKETS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .ready_init(enable),
        .q_empty(q_empty), .q_item(q_item), .q_bucket(q_bucket), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

    `CHKV_ASSERT_IMP(a_full_count, aclk, aresetn, m_tvalid && (m_tdata[1:0] == ST_FULL), m_tdata[76:66] == 11'(NODES))
    `CHKV_ASSERT_IMP(a_null_zero, aclk, aresetn, m_tvalid && (m_tdata[1:0] == ST_NULLKEY), m_tdata[65:2] == 64'd0)
    `CHKV_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

// ===== hdl/chkv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/chkv_front.sv =====
// ----------------------------------------------------------------------------
// Chained hash key-value table front end
// Accepts items, classifies them and reduces the key to its bucket.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chkv_front #(
    parameter int BUCKETS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 enable,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // op[1:0], key[65:2], value[129:66]
    input  logic [135:0]         s_tdata,
    output logic                 push,
    output chkv_pkg::item_t      push_item,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] push_bucket,
    input  logic                 q_full
);
    import chkv_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [BW:0] BMOD = (BW+1)'(BUCKETS);

    item_t       item_reg;
    logic [63:0] sh_reg;
    logic [BW:0] r_reg, r_next;
    logic [2:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [1:0]  in_op;
    logic [63:0] in_key;

    assign in_op  = s_tdata[1:0];
    assign in_key = s_tdata[65:2];
    assign s_tready = enable && !busy_reg;
    assign push = done_reg && !q_full;
    assign push_item = item_reg;
    assign push_bucket = r_reg[BW-1:0];

    always_comb begin
        logic [BW:0] r;
        r = r_reg;
        for (int i = 0; i < 8; i++) begin
            r = {r[BW-1:0], sh_reg[63-i]};
            if (r >= BMOD) begin
                r = r - BMOD;
            end
        end
        r_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (s_tvalid && s_tready) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg && !done_reg) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                done_reg <= 1'b1;
            end
        end else if (push) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op    <= in_op;
            item_reg.key   <= in_key;
            item_reg.value <= s_tdata[129:66];
            if (in_op == OP_NOP) begin
                item_reg.kind <= K_NOP;
            end else if (in_key == 64'd0) begin
                item_reg.kind <= K_NULL;
            end else if (in_op == OP_ADD) begin
                item_reg.kind <= K_ADD;
            end else begin
                item_reg.kind <= K_LOOK;
            end
            sh_reg <= in_key;
            r_reg  <= '0;
        end else if (busy_reg && !done_reg) begin
            sh_reg <= {sh_reg[55:0], 8'd0};
            r_reg  <= r_next;
        end
    end
endmodule

// ===== hdl/chkv_fifo.sv =====
// ----------------------------------------------------------------------------
// Two-entry queue
// Holds classified items between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chkv_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end
endmodule

// ===== hdl/chkv_back.sv =====
// ----------------------------------------------------------------------------
// Chained hash key-value table back end
// Walks bucket chains and relinks nodes in the node and bucket memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chkv_back #(
    parameter int NODES   = 1024,
    parameter int BUCKETS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    output logic                 ready_init,
    input  logic                 q_empty,
    input  chkv_pkg::item_t      q_item,
    input  logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] q_bucket,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], found_value[65:2], entry_count[76:66]
    output logic [79:0]          m_tdata
);
    import chkv_pkg::*;

    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NAW  = $clog2(NODES);
    localparam int LW   = $clog2(NODES + 1);
    localparam int MAXD = (NODES > BUCKETS) ? NODES : BUCKETS;
    localparam int CLW  = $clog2(MAXD + 1);
    localparam logic [LW-1:0] NIL = LW'(NODES);

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_ADD1  = 10'b0000000100,
        S_ADD2  = 10'b0000001000,
        S_ADD3  = 10'b0000010000,
        S_FHEAD = 10'b0000100000,
        S_CMP   = 10'b0001000000,
        S_REL1  = 10'b0010000000,
        S_REL2  = 10'b0100000000,
        S_REL3  = 10'b1000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CLW-1:0]  clr_reg;
    item_t           cur_reg;
    logic [BW-1:0]   bkt_reg;
    logic [LW-1:0]   fh_reg, c_reg, p_reg, x_reg, fn_reg, old_reg;
    logic [LW-1:0]   cnt_reg;
    logic [63:0]     data_reg;
    logic            ov_reg;
    logic [79:0]     od_reg;

    logic            key_we, val_we, nxt_we, prv_we, bh_we;
    logic [NAW-1:0]  key_wa, val_wa, nxt_wa, prv_wa, node_ra, nxt_ra;
    logic [63:0]     key_wd, val_wd, key_rd, val_rd;
    logic [LW-1:0]   nxt_wd, prv_wd, nxt_rd, prv_rd, bh_wd, bh_rd;
    logic [BW-1:0]   bh_wa, bh_ra;

    logic            res_en;
    logic [1:0]      res_st;
    logic [63:0]     res_data;
    logic [LW-1:0]   res_cnt;

    assign ready_init = (state_reg != S_INIT);
    assign pop = (state_reg == S_IDLE) && !q_empty && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata = od_reg;

    chkv_ram #(.WIDTH(64), .DEPTH(NODES)) u_key (
        .aclk(aclk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
        .raddr(node_ra), .rdata(key_rd));
    chkv_ram #(.WIDTH(64), .DEPTH(NODES)) u_val (
        .aclk(aclk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
        .raddr(node_ra), .rdata(val_rd));
    chkv_ram #(.WIDTH(LW), .DEPTH(NODES)) u_nxt (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .raddr(nxt_ra), .rdata(nxt_rd));
    chkv_ram #(.WIDTH(LW), .DEPTH(NODES)) u_prv (
        .aclk(aclk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .raddr(node_ra), .rdata(prv_rd));
    chkv_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bh (
        .aclk(aclk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd),
        .raddr(bh_ra), .rdata(bh_rd));

    always_comb begin
        state_next = state_reg;
        key_we = 1'b0; key_wa = c_reg[NAW-1:0]; key_wd = cur_reg.key;
        val_we = 1'b0; val_wa = c_reg[NAW-1:0]; val_wd = cur_reg.value;
        nxt_we = 1'b0; nxt_wa = c_reg[NAW-1:0]; nxt_wd = old_reg;
        prv_we = 1'b0; prv_wa = c_reg[NAW-1:0]; prv_wd = NIL;
        bh_we  = 1'b0; bh_wa  = bkt_reg;        bh_wd  = c_reg;
        bh_ra  = q_bucket;
        nxt_ra = fh_reg[NAW-1:0];
        node_ra = nxt_rd[NAW-1:0];
        res_en = 1'b0; res_st = ST_OK; res_data = 64'd0; res_cnt = cnt_reg;
        unique case (state_reg)
            S_INIT: begin
                nxt_we = (clr_reg < CLW'(NODES));
                nxt_wa = clr_reg[NAW-1:0];
                nxt_wd = LW'(clr_reg + CLW'(1));
                prv_we = nxt_we;
                prv_wa = clr_reg[NAW-1:0];
                prv_wd = (clr_reg == '0) ? NIL : LW'(clr_reg - CLW'(1));
                bh_we  = (clr_reg < CLW'(BUCKETS));
                bh_wa  = clr_reg[BW-1:0];
                bh_wd  = NIL;
                if (clr_reg == CLW'(MAXD - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    unique case (q_item.kind)
                        K_NOP: begin
                            res_en = 1'b1;
                        end
                        K_NULL: begin
                            res_en = 1'b1;
                            res_st = ST_NULLKEY;
                        end
                        K_ADD: begin
                            if (fh_reg == NIL) begin
                                res_en = 1'b1;
                                res_st = ST_FULL;
                            end else begin
                                state_next = S_ADD1;
                            end
                        end
                        default: begin
                            state_next = S_FHEAD;
                        end
                    endcase
                end
            end
            S_ADD1: begin
                key_we = 1'b1;
                val_we = 1'b1;
                nxt_we = 1'b1; nxt_wd = bh_rd;
                prv_we = 1'b1;
                bh_we  = 1'b1;
                state_next = S_ADD2;
            end
            S_ADD2: begin
                prv_we = (fn_reg != NIL);
                prv_wa = fn_reg[NAW-1:0];
                state_next = S_ADD3;
            end
            S_ADD3: begin
                prv_we = (old_reg != NIL);
                prv_wa = old_reg[NAW-1:0];
                prv_wd = c_reg;
                res_en = 1'b1;
                res_cnt = cnt_reg + LW'(1);
                state_next = S_IDLE;
            end
            S_FHEAD: begin
                node_ra = bh_rd[NAW-1:0];
                nxt_ra  = bh_rd[NAW-1:0];
                if (bh_rd == NIL) begin
                    res_en = 1'b1;
                    res_st = ST_MISSING;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                nxt_ra = nxt_rd[NAW-1:0];
                if (key_rd == cur_reg.key) begin
                    if (cur_reg.op == OP_FIND) begin
                        res_en = 1'b1;
                        res_data = val_rd;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_REL1;
                    end
                end else if (nxt_rd == NIL) begin
                    res_en = 1'b1;
                    res_st = ST_MISSING;
                    state_next = S_IDLE;
                end
            end
            S_REL1: begin
                if (p_reg != NIL) begin
                    nxt_we = 1'b1;
                    nxt_wa = p_reg[NAW-1:0];
                    nxt_wd = x_reg;
                end else begin
                    bh_we = 1'b1;
                    bh_wd = x_reg;
                end
                prv_we = 1'b1;
                state_next = S_REL2;
            end
            S_REL2: begin
                prv_we = (x_reg != NIL);
                prv_wa = x_reg[NAW-1:0];
                prv_wd = p_reg;
                nxt_we = 1'b1;
                nxt_wd = fh_reg;
                state_next = S_REL3;
            end
            S_REL3: begin
                prv_we = (fh_reg != NIL);
                prv_wa = fh_reg[NAW-1:0];
                prv_wd = c_reg;
                res_en = 1'b1;
                res_data = data_reg;
                res_cnt = cnt_reg - LW'(1);
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            clr_reg   <= '0;
            fh_reg    <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INIT) begin
                clr_reg <= clr_reg + CLW'(1);
            end
            if (state_reg == S_ADD1) begin
                fh_reg <= nxt_rd;
            end
            if (state_reg == S_REL3) begin
                fh_reg <= c_reg;
            end
            if (res_en) begin
                cnt_reg <= res_cnt;
                ov_reg  <= 1'b1;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_item;
            bkt_reg <= q_bucket;
            c_reg   <= fh_reg;
        end
        if (state_reg == S_ADD1) begin
            fn_reg  <= nxt_rd;
            old_reg <= bh_rd;
        end
        if (state_reg == S_FHEAD) begin
            c_reg <= bh_rd;
        end
        if (state_reg == S_CMP) begin
            if (key_rd == cur_reg.key) begin
                p_reg    <= prv_rd;
                x_reg    <= nxt_rd;
                data_reg <= val_rd;
            end else begin
                c_reg <= nxt_rd;
            end
        end
        if (res_en) begin
            od_reg <= {3'd0, 11'(res_cnt), res_data, res_st};
        end
    end
endmodule
